@@ rtl/sha256_pkg.sv @@
package sha256_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned DIGEST_WORDS = 8;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS = 64;

   typedef logic [WORD_WIDTH-1:0] word_type;

   localparam word_type INIT_HASH [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_CONST [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LENGTH_START = 6'd56;

   // controller -> datapath commands
   typedef struct packed {
      logic       put_byte;     // write byte_val into window at offset
      logic [7:0] byte_val;
      logic       load_vars;    // a..h <= chain
      logic       round;        // one compression round
      logic [5:0] round_num;
      logic       add_chain;    // chain += a..h
      logic       init_chain;   // chain <= initial values
      logic       shift_out;    // rotate chain for output
   } sha256_cmd_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WORD_WIDTH - n));
   endfunction

endpackage

@@ rtl/sha256_datapath.sv @@
module sha256_datapath
   import sha256_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  sha256_cmd_type cmd,
   input  logic [5:0]     offset,
   output word_type       chain_head
);

   word_type chain_ff [DIGEST_WORDS];
   word_type chain_in [DIGEST_WORDS];
   word_type vars_ff  [DIGEST_WORDS];
   word_type vars_in  [DIGEST_WORDS];
   word_type win_ff   [BLOCK_WORDS];
   word_type win_in   [BLOCK_WORDS];

   word_type w15, w2, sg0, sg1, w_new, w_cur;
   word_type bs1, ch, t1, bs0, mj;
   logic [3:0] ridx;

   assign ridx = cmd.round_num[3:0];

   // message schedule
   always_comb begin
      w15   = win_ff[ridx + 4'd1];
      w2    = win_ff[ridx + 4'd14];
      sg0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      sg1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      w_new = win_ff[ridx] + sg0 + win_ff[ridx + 4'd9] + sg1;
      w_cur = (cmd.round_num >= 6'd16) ? w_new : win_ff[ridx];
   end

   // round function
   always_comb begin
      bs1 = rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25);
      ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      t1  = vars_ff[7] + bs1 + ch + ROUND_CONST[cmd.round_num] + w_cur;
      bs0 = rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22);
      mj  = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^
            (vars_ff[1] & vars_ff[2]);
   end

   // next state
   always_comb begin
      chain_in = chain_ff;
      vars_in  = vars_ff;
      win_in   = win_ff;
      if (cmd.put_byte) begin
         win_in[offset[5:2]][(5'd3 - {3'd0, offset[1:0]}) * 8 +: 8] = cmd.byte_val;
      end
      if (cmd.round) begin
         win_in[ridx] = w_cur;
         for (int i = 7; i > 0; i--) vars_in[i] = vars_ff[i-1];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[0] = t1 + bs0 + mj;
      end
      if (cmd.load_vars) vars_in = chain_ff;
      if (cmd.add_chain) begin
         for (int i = 0; i < DIGEST_WORDS; i++) chain_in[i] = chain_ff[i] + vars_ff[i];
      end
      if (cmd.shift_out) begin
         for (int i = 0; i < DIGEST_WORDS - 1; i++) chain_in[i] = chain_ff[i+1];
         chain_in[DIGEST_WORDS-1] = chain_ff[0];
      end
      if (cmd.init_chain) chain_in = INIT_HASH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
         vars_ff  <= '{default: '0};
      end else begin
         chain_ff <= chain_in;
         vars_ff  <= vars_in;
      end
      win_ff <= win_in;
   end

   assign chain_head = chain_ff[0];

endmodule

@@ rtl/sha256_control.sv @@
module sha256_control
   import sha256_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     in_byte,
   input  logic           in_bvalid,
   input  logic           in_end,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [2:0]     out_index,
   output sha256_cmd_type cmd,
   output logic [5:0]     offset
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_PAD   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  off_ff, off_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  idx_ff, idx_in;
   logic        fin_ff, fin_in;       // finishing message (padding)
   logic        pad1_ff, pad1_in;     // 0x80 byte still to place
   logic        lenblk_ff, lenblk_in; // current block carries the bit length

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_index = idx_ff;
   assign offset    = off_ff;

   always_comb begin
      state_in  = state_ff;
      off_in    = off_ff;
      rnd_in    = rnd_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      fin_in    = fin_ff;
      pad1_in   = pad1_ff;
      lenblk_in = lenblk_ff;
      cmd       = '0;
      cmd.round_num = rnd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (in_bvalid) begin
                  cmd.put_byte = 1'b1;
                  cmd.byte_val = in_byte;
                  off_in = off_ff + 6'd1;
                  len_in = len_ff + 64'd8;
               end
               fin_in  = in_end;
               pad1_in = in_end;
               if (in_bvalid && off_ff == 6'd63) state_in = ST_LOAD;
               else if (in_end) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // one padding byte per cycle
            cmd.put_byte = 1'b1;
            pad1_in = 1'b0;
            if (pad1_ff) begin
               cmd.byte_val = PAD_BYTE;
               // length fits behind the 0x80 byte only if it lands before the length field
               lenblk_in = (off_ff < LENGTH_START);
            end else if (lenblk_ff && off_ff >= LENGTH_START)
               cmd.byte_val = len_ff[(6'd63 - off_ff) * 8 +: 8];
            else cmd.byte_val = 8'd0;
            off_in = off_ff + 6'd1;
            if (off_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_vars = 1'b1;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            // done with message once the block holding the length is compressed
            if (!fin_ff) state_in = ST_IDLE;
            else if (pad1_ff) state_in = ST_PAD;
            else if (lenblk_ff) state_in = ST_OUT;
            else begin
               // 0x80 landed in the length field: one more block of zeros and length
               lenblk_in = 1'b1;
               state_in  = ST_PAD;
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               cmd.shift_out = 1'b1;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.init_chain = 1'b1;
                  len_in    = '0;
                  fin_in    = 1'b0;
                  lenblk_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         off_ff    <= '0;
         rnd_ff    <= '0;
         len_ff    <= '0;
         idx_ff    <= '0;
         fin_ff    <= 1'b0;
         pad1_ff   <= 1'b0;
         lenblk_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         off_ff    <= off_in;
         rnd_ff    <= rnd_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         fin_ff    <= fin_in;
         pad1_ff   <= pad1_in;
         lenblk_ff <= lenblk_in;
      end
   end

endmodule

@@ rtl/sha256_message_hasher_core.sv @@
// Per 64-byte block: the bytes are written into the window, then a load, 64 rounds and an add.
// Input is not taken while a block is compressed; the rounds share the single round unit.
// End of message: padding one byte per cycle, one or two last compressions, then 8 digest transfers.
// Reset: synchronous, active high; restores initial hash values and clears length.
module sha256_message_hasher_core
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] message_byte
   input  logic        req_tuser,  // byte_valid
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast   // last_word
);

   sha256_cmd_type cmd;
   logic [5:0]     offset;
   logic [2:0]     out_index;
   word_type       chain_head;

   sha256_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_bvalid (req_tuser),
      .in_end    (req_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (out_index),
      .cmd       (cmd),
      .offset    (offset)
   );

   sha256_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .offset     (offset),
      .chain_head (chain_head)
   );

   assign rsp_tdata = {5'd0, out_index, chain_head};
   assign rsp_tlast = (out_index == 3'd7);

endmodule

@@ tb/tb_top.sv @@
module tb_top
   import sha256_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       eom;
   } msg_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;  // [7:0] message_byte
   logic        req_tuser;  // byte_valid
   logic        req_tlast;  // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;  // [31:0] digest_word, [34:32] word_index, zero fill
   logic        rsp_tlast;  // last_word

   sha256_message_hasher_core i_dut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // hasher state kept by the predictor
   logic [31:0] hash_chain [8];
   logic [31:0] block_words [16];
   logic [5:0]  fill_count;
   logic [63:0] bit_count;

   msg_item_type    pending_bytes [$];
   digest_item_type expected_digest [$];
   int  mismatch_count = 0;
   int  messages_done = 0;
   int  bytes_sent = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_sender = 1'b0;
   int  quiet_cycles = 0;
   localparam int QUIET_LIMIT = 20000;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] v [8];
      logic [31:0] w15, w2, s0, s1, t1, t2, e, a;
      int r;
      for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
      for (r = 0; r < 64; r++) begin
         if (r >= 16) begin
            w15 = block_words[(r - 15) & 15];
            w2 = block_words[(r - 2) & 15];
            s0 = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
            s1 = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
            block_words[r & 15] = block_words[r & 15] + s0 + block_words[(r - 7) & 15] + s1;
         end
         e = v[4];
         a = v[0];
         t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
            + ROUND_CONST[r] + block_words[r & 15];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) ^ 32'h0;
         t2 = t2 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
   endtask

   task automatic absorb_byte(logic [7:0] b);
      int idx, sh;
      idx = fill_count[5:2];
      sh = (3 - fill_count[1:0]) * 8;
      block_words[idx] = (block_words[idx] & ~(32'hff << sh)) | (32'(b) << sh);
      fill_count++;
      if (fill_count == 0) compress_block();
   endtask

   task automatic hash_reset();
      for (int i = 0; i < 8; i++) hash_chain[i] = INIT_HASH[i];
      fill_count = 0;
      bit_count = 0;
   endtask

   task automatic predict_digest(msg_item_type it);
      logic [63:0] len;
      digest_item_type d;
      if (it.has_byte) begin
         absorb_byte(it.data);
         bit_count += 64'd8;
      end
      if (it.eom) begin
         len = bit_count;
         absorb_byte(PAD_BYTE);
         while (fill_count != LENGTH_START) absorb_byte(8'h00);
         for (int i = 56; i >= 0; i -= 8) absorb_byte(len[i +: 8]);
         for (int i = 0; i < 8; i++) begin
            d = '{hash_chain[i], 3'(i), i == 7};
            expected_digest = {expected_digest, d};
         end
         hash_reset();
         messages_done++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         req_tlast <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_digest(pending_bytes.pop_front());
            bytes_sent++;
         end
         if ((!req_tvalid || req_tready) && pending_bytes.size() > 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_bytes[0].data;
            req_tuser <= pending_bytes[0].has_byte;
            req_tlast <= pending_bytes[0].eom;
         end else if (!req_tvalid || req_tready) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      digest_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digest.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected digest transfer data=%h last=%b", rsp_tdata, rsp_tlast);
            end else begin
               want = expected_digest.pop_front();
               if (rsp_tdata[31:0] !== want.word || rsp_tdata[34:32] !== want.index ||
                   rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("digest mismatch: expected %h idx %0d last %b,",
                              want.word, want.index, want.last,
                              " got %h idx %0d last %b", rsp_tdata[31:0],
                              rsp_tdata[34:32], rsp_tlast);
               end
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("sha256_message_hasher_core test failed");
            $finish;
         end
      end
   end

   task automatic queue_item(logic [7:0] data, logic has_byte, logic eom);
      msg_item_type it;
      it = '{data, has_byte, eom};
      pending_bytes = {pending_bytes, it};
   endtask

   task automatic add_message(int len, int mode);
      msg_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
         it.has_byte = 1'b1;
         it.eom = 1'b0;
         // occasional idle item mixed into the message
         if (mode == 3 && $urandom_range(9) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
         if (i == len - 1 && $urandom_range(1)) it.eom = 1'b1;
         pending_bytes = {pending_bytes, it};
      end
      if (len == 0 || !pending_bytes[$].eom) queue_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_tvalid || expected_digest.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      int len;
      hash_reset();
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, byte with end, boundary lengths, extreme bytes
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'h61, 1'b1, 1'b1);
      queue_item(8'hff, 1'b0, 1'b0);
      add_message(3, 1);
      add_message(5, 2);
      add_message(9, 0);
      wait_drained();
      add_message(55, 0);
      add_message(56, 1);
      add_message(64, 0);
      wait_drained();

      // random phases with changing handshake pressure
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 74 : (ph == 3) ? 34 : 0;
         recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 34 : 0;
         for (int m = 0; m < 3; m++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(20);
            add_message(len, 3);
         end
         if (ph == 1) begin
            // once a digest is due, sender holds until all digests are drained
            while (expected_digest.size() == 0 && pending_bytes.size() > 0) @(posedge clock);
            hold_sender = 1'b1;
            while (expected_digest.size() > 0 || req_tvalid) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end
      $display("covered %0d messages over %0d input transfers, with empty, padded-over",
               messages_done, bytes_sent);
      $display("and multi-block lengths under varied sender idling and receiver stalls");
      if (mismatch_count == 0) begin
         $display("sha256_message_hasher_core test passed");
      end else begin
         $display("sha256_message_hasher_core test failed");
      end
      $finish;
   end
endmodule
